// ----- rtl/rth_pkg.sv -----
// rgb to hue package: widths, the divider transaction type and shared constants
// no dependencies; used by every module of the rgb_to_hue_unit block
`timescale 1ns / 1ps

package rth_pkg;

  // channel and hue widths
  localparam int unsigned CHANNEL_BITS = 8;
  localparam int unsigned HUE_BITS     = 16;

  // divisor is six times the chroma, so three bits wider than a channel
  localparam int unsigned DEN_BITS = CHANNEL_BITS + 3;
  // signed working width of the sector numerator
  localparam int unsigned SUM_BITS = CHANNEL_BITS + 4;

  // sector offsets in units of the chroma
  localparam int unsigned GREEN_OFFSET = 2;
  localparam int unsigned BLUE_OFFSET  = 4;
  localparam int unsigned TURN_SECTORS = 6;

  typedef logic [CHANNEL_BITS-1:0] chan_t;
  typedef logic [DEN_BITS-1:0]     den_t;
  typedef logic [HUE_BITS-1:0]     hue_t;

  // partial division handed from one cell to the next
  typedef struct packed {
    den_t rem;  // running remainder, always below den
    den_t den;  // divisor, six times the chroma (one for a gray pixel)
    hue_t quo;  // quotient bits gathered so far, lsb most recent
  } div_t;

endpackage

// ----- rtl/rth_if.sv -----
// rgb to hue channel interfaces: pixel input and hue result, valid/ready handshake
// depends on rth_pkg for the payload widths
`timescale 1ns / 1ps

interface rth_pix_if;
  logic          valid;
  logic          ready;
  rth_pkg::chan_t red;
  rth_pkg::chan_t green;
  rth_pkg::chan_t blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

interface rth_hue_if;
  logic          valid;
  logic          ready;
  rth_pkg::hue_t hue_turn;

  modport source (output valid, output hue_turn, input ready);
  modport sink (input valid, input hue_turn, output ready);
endinterface

// ----- rtl/rth_prep.sv -----
// rgb to hue front stage: max, min, chroma, sector numerator and divisor
// depends on rth_pkg; feeds the first divider cell
`timescale 1ns / 1ps

module rth_prep (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  rth_pkg::chan_t red_i,
  input  rth_pkg::chan_t green_i,
  input  rth_pkg::chan_t blue_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output rth_pkg::div_t  out_data_o
);

  logic signed [rth_pkg::SUM_BITS-1:0] r_s, g_s, b_s, hi_s, lo_s, c_s, n_s;
  logic signed [rth_pkg::SUM_BITS-1:0] six_c;
  rth_pkg::div_t data_d, data_q;
  logic valid_q;
  logic load;

  // widen channels to signed working width
  assign r_s = $signed({{(rth_pkg::SUM_BITS-rth_pkg::CHANNEL_BITS){1'b0}}, red_i});
  assign g_s = $signed({{(rth_pkg::SUM_BITS-rth_pkg::CHANNEL_BITS){1'b0}}, green_i});
  assign b_s = $signed({{(rth_pkg::SUM_BITS-rth_pkg::CHANNEL_BITS){1'b0}}, blue_i});

  // max, min and chroma
  always_comb begin
    hi_s = (r_s > g_s) ? r_s : g_s;
    hi_s = (hi_s > b_s) ? hi_s : b_s;
    lo_s = (r_s < g_s) ? r_s : g_s;
    lo_s = (lo_s < b_s) ? lo_s : b_s;
    c_s  = hi_s - lo_s;
  end

  assign six_c = c_s * $signed(SUM_BITS_SIX());

  function automatic logic signed [rth_pkg::SUM_BITS-1:0] SUM_BITS_SIX();
    SUM_BITS_SIX = rth_pkg::SUM_BITS'(rth_pkg::TURN_SECTORS);
  endfunction

  // sector numerator, green tested first, then blue; gray gets divisor one
  always_comb begin
    if (hi_s == g_s) begin
      n_s = (b_s - r_s) + c_s * $signed(rth_pkg::SUM_BITS'(rth_pkg::GREEN_OFFSET));
    end else if (hi_s == b_s) begin
      n_s = (r_s - g_s) + c_s * $signed(rth_pkg::SUM_BITS'(rth_pkg::BLUE_OFFSET));
    end else begin
      n_s = g_s - b_s;
      if (n_s < 0) begin
        n_s = n_s + six_c;
      end
    end
    if (c_s == 0) begin
      data_d.rem = '0;
      data_d.den = rth_pkg::DEN_BITS'(1);
    end else begin
      data_d.rem = n_s[rth_pkg::DEN_BITS-1:0];
      data_d.den = six_c[rth_pkg::DEN_BITS-1:0];
    end
    data_d.quo = '0;
  end

  // stage handshake
  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ----- rtl/rth_div_cell.sv -----
// rgb to hue divider cell: one restoring step, one quotient bit per cell
// depends on rth_pkg; cells are chained in rgb_to_hue_unit
`timescale 1ns / 1ps

module rth_div_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rth_pkg::div_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output rth_pkg::div_t out_data_o
);

  logic [rth_pkg::DEN_BITS:0] rem2, diff;
  logic                       take;
  rth_pkg::div_t              data_d, data_q;
  logic                       valid_q;
  logic                       load;

  // double the remainder and try the divisor
  always_comb begin
    rem2 = {in_data_i.rem, 1'b0};
    diff = rem2 - {1'b0, in_data_i.den};
    take = (rem2 >= {1'b0, in_data_i.den});
    data_d.den = in_data_i.den;
    data_d.rem = take ? diff[rth_pkg::DEN_BITS-1:0] : rem2[rth_pkg::DEN_BITS-1:0];
    data_d.quo = {in_data_i.quo[rth_pkg::HUE_BITS-2:0], take};
  end

  // stage handshake
  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ----- rtl/rgb_to_hue_unit.sv -----
// rgb to hue top level: front stage plus a chain of divider cells
// depends on rth_pkg, rth_if, rth_prep and rth_div_cell
`timescale 1ns / 1ps

// Converts one 8-bit RGB pixel to its HSV hue as an unsigned 16-bit fraction of a
// turn (0 red, one third green, two thirds blue; gray gives 0), truncated. A new
// pixel is taken every clock while the output does not stall; each result passes through
// one front stage forming max, min, chroma and sector numerator, then a chain of
// 16 divider cells that each resolve one quotient bit against six times the
// chroma. Every stage has its own valid and ready, so the chain keeps filling
// while a finished hue waits at the output.
module rgb_to_hue_unit (
  input logic    clk_i,
  input logic    rst_ni,
  rth_pix_if.sink   pix_i,
  rth_hue_if.source hue_o
);

  logic          stg_valid [0:rth_pkg::HUE_BITS];
  logic          stg_ready [0:rth_pkg::HUE_BITS];
  rth_pkg::div_t stg_data  [0:rth_pkg::HUE_BITS];

  // front stage
  rth_prep u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pix_i.valid),
    .in_ready_o (pix_i.ready),
    .red_i      (pix_i.red),
    .green_i    (pix_i.green),
    .blue_i     (pix_i.blue),
    .out_valid_o(stg_valid[0]),
    .out_ready_i(stg_ready[0]),
    .out_data_o (stg_data[0])
  );

  // divider chain, msb of the quotient first
  for (genvar k = 0; k < rth_pkg::HUE_BITS; k++) begin : g_cell
    rth_div_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .in_valid_i (stg_valid[k]),
      .in_ready_o (stg_ready[k]),
      .in_data_i  (stg_data[k]),
      .out_valid_o(stg_valid[k+1]),
      .out_ready_i(stg_ready[k+1]),
      .out_data_o (stg_data[k+1])
    );
  end

  // result channel
  assign stg_ready[rth_pkg::HUE_BITS] = hue_o.ready;
  assign hue_o.valid    = stg_valid[rth_pkg::HUE_BITS];
  assign hue_o.hue_turn = stg_data[rth_pkg::HUE_BITS].quo;

  // divisor is never zero leaving the front stage
  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stg_valid[0] |-> (stg_data[0].den != '0))
    else $error("zero divisor entered the divider chain");

  // remainder stays below the divisor at the end of the chain
  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hue_o.valid |-> (stg_data[rth_pkg::HUE_BITS].rem < stg_data[rth_pkg::HUE_BITS].den))
    else $error("divider remainder not below divisor");

  // an empty output stage lets the whole chain advance
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!hue_o.valid && hue_o.ready) |-> pix_i.ready)
    else $error("input stalled although the output is free");

endmodule

// ----- tb/rgb_to_hue_unit_test.sv -----
// testbench for rgb_to_hue_unit: random and directed pixels, hue checked against a local predictor
// depends on rth_pkg, rth_if and the rgb_to_hue_unit rtl
`timescale 1ns / 1ps

module rgb_to_hue_unit_test;

  localparam int unsigned RANDOM_PIXELS = 1050;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  // extra cycles run after the last expected hue has been checked
  localparam int unsigned DRAIN_CYCLES  = 24;

  // expected hues in arrival order plus the mismatch count
  class hue_scoreboard;
    rth_pkg::hue_t expected_hues[$];
    int            mismatches;

    function new();
      mismatches = 0;
    endfunction

    // hsv hue of one pixel as a fraction of a turn, truncated
    function rth_pkg::hue_t hue_of_pixel(rth_pkg::chan_t r, rth_pkg::chan_t g,
                                         rth_pkg::chan_t b);
      longint red_l, green_l, blue_l, top, bottom, chroma, num;
      red_l   = longint'(r);
      green_l = longint'(g);
      blue_l  = longint'(b);
      top     = red_l > green_l ? red_l : green_l;
      top     = top > blue_l ? top : blue_l;
      bottom  = red_l < green_l ? red_l : green_l;
      bottom  = bottom < blue_l ? bottom : blue_l;
      chroma  = top - bottom;
      if (chroma == 0) return '0;
      // green wins ties first, then blue, then red
      if (top == green_l) begin
        num = (blue_l - red_l) + 2 * chroma;
      end else if (top == blue_l) begin
        num = (red_l - green_l) + 4 * chroma;
      end else begin
        num = green_l - blue_l;
        if (num < 0) num = num + 6 * chroma;
      end
      return rth_pkg::hue_t'((num << rth_pkg::HUE_BITS) / (6 * chroma));
    endfunction

    function void note_pixel(rth_pkg::chan_t r, rth_pkg::chan_t g, rth_pkg::chan_t b);
      expected_hues.push_back(hue_of_pixel(r, g, b));
    endfunction

    function int pending();
      return expected_hues.size();
    endfunction

    task report_mismatch(string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatches++;
    endtask

    task check_hue(rth_pkg::hue_t got);
      rth_pkg::hue_t want;
      if (expected_hues.size() == 0) begin
        report_mismatch($sformatf("hue_turn %0d with no pixel outstanding", got));
      end else begin
        want = expected_hues.pop_front();
        if (got !== want)
          report_mismatch($sformatf("hue_turn %0d, expected %0d", got, want));
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  bit   steady;   // when set, neither side idles
  int unsigned cycles = 0;

  rth_pix_if pix ();
  rth_hue_if hue ();

  hue_scoreboard board;

  rgb_to_hue_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix),
    .hue_o  (hue)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // idle cycles before the next transaction, about 30 percent of cycles
  function int idle_gap();
    int gap;
    gap = 0;
    if (!steady) begin
      while ($urandom_range(99) < 30) gap++;
    end
    return gap;
  endfunction

  // offer one pixel and wait until it is taken
  task send_pixel(input rth_pkg::chan_t r, input rth_pkg::chan_t g,
                  input rth_pkg::chan_t b);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix.valid <= 1'b1;
    pix.red   <= r;
    pix.green <= g;
    pix.blue  <= b;
    @(posedge clk_i);
    while (!pix.ready) @(posedge clk_i);
    board.note_pixel(r, g, b);
  endtask

  // random pixel, biased toward grays, ties and small chroma
  task send_random_pixel();
    rth_pkg::chan_t r, g, b, lvl;
    int             kind;
    r    = rth_pkg::chan_t'($urandom);
    g    = rth_pkg::chan_t'($urandom);
    b    = rth_pkg::chan_t'($urandom);
    lvl  = rth_pkg::chan_t'($urandom);
    kind = $urandom_range(9);
    case (kind)
      0: begin
        r = lvl; g = lvl; b = lvl;
      end
      1: begin
        case ($urandom_range(2))
          0: g = r;
          1: b = g;
          default: b = r;
        endcase
      end
      2: begin
        g = rth_pkg::chan_t'(r + $urandom_range(1) - $urandom_range(1));
        b = rth_pkg::chan_t'(r + $urandom_range(1) - $urandom_range(1));
      end
      default: ;
    endcase
    send_pixel(r, g, b);
  endtask

  // hue sink: check every transaction, stall at random unless steady is set
  task run_hue_sink();
    forever begin
      @(posedge clk_i);
      if (hue.valid && hue.ready) board.check_hue(hue.hue_turn);
      hue.ready <= steady ? 1'b1 : ($urandom_range(99) >= 30);
    end
  endtask

  task wait_for_drain();
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    board = new();
    steady = 1'b0;
    rst_ni <= 1'b0;
    pix.valid <= 1'b0;
    pix.red   <= '0;
    pix.green <= '0;
    pix.blue  <= '0;
    hue.ready <= 1'b0;
    fork
      run_hue_sink();
    join_none
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // grays
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    // primaries
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    // ties for the maximum
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    // red sector, including negative numerators that wrap
    send_pixel(8'd255, 8'd0, 8'd1);
    send_pixel(8'd255, 8'd0, 8'd254);
    send_pixel(8'd255, 8'd1, 8'd0);
    // chroma of one
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd1, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd1);
    send_pixel(8'd255, 8'd254, 8'd254);
    send_pixel(8'd254, 8'd255, 8'd254);
    send_pixel(8'd1, 8'd0, 8'd1);
    // alternating bit patterns
    send_pixel(8'hAA, 8'h55, 8'h0F);
    send_pixel(8'h55, 8'hAA, 8'hF0);
    send_pixel(8'h0F, 8'hF0, 8'hAA);

    // hold off until the pipeline is empty
    pix.valid <= 1'b0;
    wait_for_drain();
    @(posedge clk_i);

    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      // back-to-back stretch with no idling on either side
      steady = (i >= 400 && i < 650);
      send_random_pixel();
    end
    steady = 1'b0;
    pix.valid <= 1'b0;

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
